@@ sv/lpts_pkg.sv @@
package lpts_pkg;

  // Positions a pattern word can hold, and the build-time cap on the width.
  localparam int PATTERN_SLOTS = 16;
  localparam int MAX_WIDTH     = 16;
  localparam int USE_MAX       = (MAX_WIDTH < PATTERN_SLOTS) ? MAX_WIDTH : PATTERN_SLOTS;

  localparam int WORD_W = 2 * PATTERN_SLOTS;
  localparam int POS_W  = $clog2(PATTERN_SLOTS);
  localparam int WID_W  = 5;

  localparam logic [WID_W-1:0] WIDTH_RESET = WID_W'(16);

  // Symbol codes; code 3 reads as vacant.
  localparam logic [1:0] SYM_N = 2'd0;
  localparam logic [1:0] SYM_R = 2'd1;
  localparam logic [1:0] SYM_L = 2'd2;

  // Link of one position: vacant, root, or mated to another position.
  typedef struct packed {
    logic             occ;
    logic             root;
    logic [POS_W-1:0] mate;
  } link_t;

  // Stack cell control, shared by the whole chain.
  typedef struct packed {
    logic clr;
    logic push;
    logic pop;
  } cell_ctl_t;

  // Scan result handed to the top level.
  typedef struct packed {
    logic              done;
    link_t             at_i;
    link_t             at_j;
    logic [WORD_W-1:0] clean;
  } scan_res_t;

  function automatic logic [WORD_W-1:0] set_sym(input logic [WORD_W-1:0] word,
                                                input logic [POS_W-1:0]  idx,
                                                input logic [1:0]        sym);
    logic [WORD_W-1:0] r;
    r = word;
    r[2*idx +: 2] = sym;
    return r;
  endfunction

  function automatic logic [1:0] get_sym(input logic [WORD_W-1:0] word,
                                         input logic [POS_W-1:0]  idx);
    return word[2*idx +: 2];
  endfunction

endpackage

@@ sv/lpts_cell.sv @@
// One entry of the bracket stack; shifts toward the top on pop, away on push.
module lpts_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  lpts_pkg::cell_ctl_t        ctl,
  input  logic [lpts_pkg::POS_W-1:0] left_data,
  input  logic                       left_valid,
  input  logic [lpts_pkg::POS_W-1:0] right_data,
  input  logic                       right_valid,
  output logic [lpts_pkg::POS_W-1:0] data,
  output logic                       valid
);

  logic [lpts_pkg::POS_W-1:0] data_r;
  logic                       valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      priority if (ctl.clr) begin
        valid_r <= 1'b0;
      end else if (ctl.push) begin
        valid_r <= left_valid;
      end else if (ctl.pop) begin
        valid_r <= right_valid;
      end else begin
        valid_r <= valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    priority if (ctl.push) begin
      data_r <= left_data;
    end else if (ctl.pop) begin
      data_r <= right_data;
    end else begin
      data_r <= data_r;
    end
  end

  assign data  = data_r;
  assign valid = valid_r;

endmodule

@@ sv/lpts_scan.sv @@
// Walks the word one position per cycle, matching brackets on the cell chain.
module lpts_scan (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lpts_pkg::WORD_W-1:0] pattern,
  input  logic [lpts_pkg::POS_W-1:0] pos,
  input  logic [lpts_pkg::WID_W-1:0] width,
  output lpts_pkg::scan_res_t        res
);

  localparam int D = lpts_pkg::USE_MAX;

  logic                          busy_r;
  logic                          done_r;
  logic [lpts_pkg::POS_W-1:0]    k_r;
  logic [lpts_pkg::WID_W-1:0]    w_r;
  logic [lpts_pkg::POS_W-1:0]    pos_r;
  logic [lpts_pkg::WORD_W-1:0]   pat_r;
  logic [lpts_pkg::WORD_W-1:0]   clean_r;
  logic [lpts_pkg::WORD_W-1:0]   clean_nxt;
  logic                          root_seen_r;
  logic                          root_seen_nxt;
  lpts_pkg::link_t               at_i_r;
  lpts_pkg::link_t               at_i_nxt;
  lpts_pkg::link_t               at_j_r;
  lpts_pkg::link_t               at_j_nxt;

  logic [lpts_pkg::POS_W-1:0]    cell_data [D];
  logic [D-1:0]                  valid_vec;
  lpts_pkg::cell_ctl_t           ctl;
  logic [1:0]                    sym;
  logic [lpts_pkg::POS_W-1:0]    top;
  logic [lpts_pkg::POS_W-1:0]    pos_j;
  logic                          k_last;

  assign sym    = pat_r[1:0];
  assign top    = cell_data[0];
  assign pos_j  = pos_r + lpts_pkg::POS_W'(1);
  assign k_last = ({1'b0, k_r} == (w_r - lpts_pkg::WID_W'(1)));

  assign ctl.clr  = start;
  assign ctl.push = busy_r && (sym == lpts_pkg::SYM_L);
  assign ctl.pop  = busy_r && (sym == lpts_pkg::SYM_R) && valid_vec[0];

  for (genvar j = 0; j < D; j++) begin : g_cell
    logic [lpts_pkg::POS_W-1:0] l_data;
    logic                       l_valid;
    logic [lpts_pkg::POS_W-1:0] r_data;
    logic                       r_valid;

    if (j == 0) begin : g_head
      assign l_data  = k_r;
      assign l_valid = 1'b1;
    end else begin : g_body
      assign l_data  = cell_data[j-1];
      assign l_valid = valid_vec[j-1];
    end

    if (j == D - 1) begin : g_tail
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_link
      assign r_data  = cell_data[j+1];
      assign r_valid = valid_vec[j+1];
    end

    lpts_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[j]),
      .valid       (valid_vec[j])
    );
  end

  // Closing a pair writes both ends; the first unmatched close is the root.
  always_comb begin
    clean_nxt     = clean_r;
    root_seen_nxt = root_seen_r;
    at_i_nxt      = at_i_r;
    at_j_nxt      = at_j_r;
    if (ctl.pop) begin
      clean_nxt = lpts_pkg::set_sym(lpts_pkg::set_sym(clean_r, top, lpts_pkg::SYM_L),
                                    k_r, lpts_pkg::SYM_R);
      if (top == pos_r) at_i_nxt = '{occ: 1'b1, root: 1'b0, mate: k_r};
      if (k_r == pos_r) at_i_nxt = '{occ: 1'b1, root: 1'b0, mate: top};
      if (top == pos_j) at_j_nxt = '{occ: 1'b1, root: 1'b0, mate: k_r};
      if (k_r == pos_j) at_j_nxt = '{occ: 1'b1, root: 1'b0, mate: top};
    end else if (busy_r && (sym == lpts_pkg::SYM_R) && !root_seen_r) begin
      root_seen_nxt = 1'b1;
      clean_nxt     = lpts_pkg::set_sym(clean_r, k_r, lpts_pkg::SYM_R);
      if (k_r == pos_r) at_i_nxt = '{occ: 1'b1, root: 1'b1, mate: '0};
      if (k_r == pos_j) at_j_nxt = '{occ: 1'b1, root: 1'b1, mate: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && k_last) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      k_r         <= '0;
      w_r         <= width;
      pos_r       <= pos;
      pat_r       <= pattern;
      clean_r     <= '0;
      root_seen_r <= 1'b0;
      at_i_r      <= '0;
      at_j_r      <= '0;
    end else if (busy_r) begin
      k_r         <= k_r + lpts_pkg::POS_W'(1);
      pat_r       <= pat_r >> 2;
      clean_r     <= clean_nxt;
      root_seen_r <= root_seen_nxt;
      at_i_r      <= at_i_nxt;
      at_j_r      <= at_j_nxt;
    end
  end

  assign res.done  = done_r;
  assign res.at_i  = at_i_r;
  assign res.at_j  = at_j_r;
  assign res.clean = clean_r;

  // Occupied stack cells always form a run from the top.
  a_stack_packed: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_vec & (valid_vec + D'(1))) == '0)
    else $error("stack cells not contiguous");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("scan done held");

  a_one_root: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !(at_i_r.root && at_j_r.root))
    else $error("two roots found");

endmodule

@@ sv/link_pattern_tile_step.sv @@
// Items are taken one at a time: in_stall stays high from acceptance until the item's results
//   are emitted; the scan over the stack cell chain takes one position per cycle up to the width in use.
// An item gives two, one or no result beats.
// An item whose position is out of range is taken and gives no beat.
// Reset (rst_n low, synchronous): idle, no beat pending, word_width back to 16.
module link_pattern_tile_step (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 in_pattern,
  input  logic [3:0]                  in_position,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [31:0]                 out_pattern_out,
  output logic                        out_last,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [4:0]                  cfg_word_width
);

  typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_EMIT} state_t;

  state_t                        state_r;
  logic [lpts_pkg::WID_W-1:0]    word_width_r;
  logic [lpts_pkg::WID_W-1:0]    w_use;
  logic [lpts_pkg::POS_W-1:0]    pos_r;
  logic [lpts_pkg::WORD_W-1:0]   res0_r;
  logic [lpts_pkg::WORD_W-1:0]   res1_r;
  logic                          two_r;
  logic                          out_valid_r;
  logic [lpts_pkg::WORD_W-1:0]   out_pattern_out_r;
  logic                          out_last_r;

  logic                          in_acc;
  logic                          pos_ok;
  logic                          start;
  logic                          slot_free;
  lpts_pkg::scan_res_t           res;

  // Edit stage signals.
  logic [lpts_pkg::POS_W-1:0]    pi;
  logic [lpts_pkg::POS_W-1:0]    pj;
  logic [lpts_pkg::WORD_W-1:0]   s;
  logic [lpts_pkg::WORD_W-1:0]   t;
  logic [lpts_pkg::WORD_W-1:0]   r0;
  logic [lpts_pkg::WORD_W-1:0]   r1;
  logic                          two;
  logic                          none;

  // Width in use: clamp to [2, USE_MAX].
  always_comb begin
    w_use = word_width_r;
    if (w_use < lpts_pkg::WID_W'(2)) w_use = lpts_pkg::WID_W'(2);
    if (w_use > lpts_pkg::WID_W'(lpts_pkg::USE_MAX)) w_use = lpts_pkg::WID_W'(lpts_pkg::USE_MAX);
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign pos_ok    = (({1'b0, in_position} + lpts_pkg::WID_W'(1)) < w_use);
  assign start     = in_acc && pos_ok;
  assign slot_free = !out_valid_r || !out_stall;
  assign cfg_ready = 1'b1;

  lpts_scan u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .pattern (in_pattern),
    .pos     (in_position),
    .width   (w_use),
    .res     (res)
  );

  // The clean word has unmatched opens and extra closes already vacated;
  // every result is this word with a few symbols overwritten.
  assign pi = pos_r;
  assign pj = pos_r + lpts_pkg::POS_W'(1);
  assign s  = res.clean;

  always_comb begin
    r0   = s;
    r1   = s;
    two  = 1'b1;
    none = 1'b0;
    t    = lpts_pkg::set_sym(lpts_pkg::set_sym(s, pi, lpts_pkg::SYM_N), pj, lpts_pkg::SYM_N);
    unique case ({res.at_i.occ, res.at_j.occ})
      2'b00: begin
        // both vacant: new pair opened at i, closed at i+1
        r1 = lpts_pkg::set_sym(lpts_pkg::set_sym(s, pi, lpts_pkg::SYM_L), pj, lpts_pkg::SYM_R);
      end
      2'b10: begin
        // symbol slides from i to i+1; its kind stays the same
        r1 = lpts_pkg::set_sym(lpts_pkg::set_sym(s, pi, lpts_pkg::SYM_N), pj,
                               lpts_pkg::get_sym(s, pi));
      end
      2'b01: begin
        // slides from i+1 to i, moved word goes first
        r0 = lpts_pkg::set_sym(lpts_pkg::set_sym(s, pj, lpts_pkg::SYM_N), pi,
                               lpts_pkg::get_sym(s, pj));
      end
      2'b11: begin
        two = 1'b0;
        if (!res.at_i.root && (res.at_i.mate == pj)) none = 1'b1;
        // partners joined; a root on either side passes to the other's partner
        priority if (res.at_i.root) begin
          r0 = lpts_pkg::set_sym(t, res.at_j.mate, lpts_pkg::SYM_R);
        end else if (res.at_j.root) begin
          r0 = lpts_pkg::set_sym(t, res.at_i.mate, lpts_pkg::SYM_R);
        end else if (res.at_i.mate < res.at_j.mate) begin
          r0 = lpts_pkg::set_sym(lpts_pkg::set_sym(t, res.at_i.mate, lpts_pkg::SYM_L),
                                 res.at_j.mate, lpts_pkg::SYM_R);
        end else begin
          r0 = lpts_pkg::set_sym(lpts_pkg::set_sym(t, res.at_i.mate, lpts_pkg::SYM_R),
                                 res.at_j.mate, lpts_pkg::SYM_L);
        end
      end
      default: begin
        r0 = s;
      end
    endcase
  end

  // Control FSM; results wait in res0_r/res1_r until the output register frees.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      word_width_r <= lpts_pkg::WIDTH_RESET;
      out_valid_r  <= 1'b0;
      two_r        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) word_width_r <= cfg_word_width;
      // in ST_EMIT the emit arm below owns out_valid_r
      if (out_valid_r && !out_stall && (state_r != ST_EMIT)) out_valid_r <= 1'b0;
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            pos_r   <= in_position;
            state_r <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (res.done) begin
            res0_r  <= r0;
            res1_r  <= r1;
            two_r   <= two;
            state_r <= none ? ST_IDLE : ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            out_valid_r       <= 1'b1;
            out_pattern_out_r <= res0_r;
            out_last_r        <= !two_r;
            if (two_r) begin
              res0_r <= res1_r;
              two_r  <= 1'b0;
            end else begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pattern_out = out_pattern_out_r;
  assign out_last        = out_last_r;

  // Scan completes only while the FSM is waiting for it.
  a_done_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    res.done |-> (state_r == ST_SCAN))
    else $error("scan done outside scan state");

  // A first beat taken means the second is still held for emission.
  a_first_then_more: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !out_last) |-> (state_r == ST_EMIT))
    else $error("non-last beat with nothing to follow");

  // A stalled out beat holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_pattern_out) && $stable(out_last)))
    else $error("stalled out beat changed");

endmodule

@@ bench/tb_link_pattern_tile_step.sv @@
`timescale 1ns / 100ps

module tb_link_pattern_tile_step;

  // Link values per position: vacant, root defect, or the index of the mate.
  localparam int VACANT    = -2;
  localparam int ROOT_LINK = -1;
  localparam logic [1:0] SYM_JUNK = 2'd3;   // unused code, reads as vacant

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = 3 * lpts_pkg::USE_MAX + 12;  // covers an item still in flight, with margin
  localparam int PHASES       = 10;
  localparam int PHASE_ITEMS  = 190;               // in-range items per phase

  typedef int link_map_t [lpts_pkg::PATTERN_SLOTS];

  typedef struct packed {
    logic [31:0] pattern;
    logic        last;
  } tile_beat_t;

  // Predicts the result beats of each accepted word and checks the out beats.
  class tile_scoreboard;
    logic [4:0] width_reg;
    tile_beat_t expected_beats[$];
    int         errors;

    function new();
      width_reg = lpts_pkg::WIDTH_RESET;
      errors    = 0;
    endfunction

    function void set_width(logic [4:0] v);
      width_reg = v;
    endfunction

    // Width in use: register clamped to [2, USE_MAX].
    function int span();
      int w;
      w = int'(width_reg);
      if (w < 2) w = 2;
      if (w > lpts_pkg::USE_MAX) w = lpts_pkg::USE_MAX;
      return w;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // Bracket match, depth starting at 0; first stray R is the root,
    // later stray R and unclosed L read as vacant.
    function void read_links(input logic [31:0] pat, input int w, output link_map_t links);
      int opens[lpts_pkg::PATTERN_SLOTS];
      int depth;
      bit have_root;
      logic [1:0] sym;
      depth = 0;
      have_root = 0;
      for (int k = 0; k < lpts_pkg::PATTERN_SLOTS; k++) links[k] = VACANT;
      for (int k = 0; k < w; k++) begin
        sym = pat[2*k +: 2];
        if (sym == lpts_pkg::SYM_L) begin
          opens[depth] = k;
          depth++;
        end else if (sym == lpts_pkg::SYM_R) begin
          if (depth > 0) begin
            depth--;
            links[opens[depth]] = k;
            links[k] = opens[depth];
          end else if (!have_root) begin
            have_root = 1;
            links[k] = ROOT_LINK;
          end
        end
      end
    endfunction

    function logic [31:0] write_links(input link_map_t links, input int w);
      logic [31:0] word;
      logic [1:0] sym;
      word = '0;
      for (int k = 0; k < w; k++) begin
        sym = lpts_pkg::SYM_N;
        if (links[k] == ROOT_LINK) sym = lpts_pkg::SYM_R;
        else if (links[k] >= 0) sym = (k < links[k]) ? lpts_pkg::SYM_L : lpts_pkg::SYM_R;
        word[2*k +: 2] = sym;
      end
      return word;
    endfunction

    function void expect_beat(logic [31:0] word, logic last);
      tile_beat_t b;
      b.pattern = word;
      b.last    = last;
      expected_beats = {expected_beats, b};
    endfunction

    function void note_input(logic [31:0] pattern, logic [3:0] pos);
      link_map_t links, moved;
      int w, i, p, q;
      logic [31:0] same;
      bit a, b;
      w = span();
      i = int'(pos);
      if (i + 1 >= w) return;   // position out of range: no beat
      read_links(pattern, w, links);
      same  = write_links(links, w);
      moved = links;
      p = links[i];
      q = links[i+1];
      a = (p != VACANT);
      b = (q != VACANT);
      if (!a && !b) begin
        // insert an L R pair
        moved[i]   = i + 1;
        moved[i+1] = i;
        expect_beat(same, 1'b0);
        expect_beat(write_links(moved, w), 1'b1);
      end else if (a && !b) begin
        moved[i] = VACANT;
        if (p == ROOT_LINK) begin
          moved[i+1] = ROOT_LINK;
        end else begin
          moved[p]   = i + 1;
          moved[i+1] = p;
        end
        expect_beat(same, 1'b0);
        expect_beat(write_links(moved, w), 1'b1);
      end else if (!a && b) begin
        // moved word comes first here
        moved[i+1] = VACANT;
        if (q == ROOT_LINK) begin
          moved[i] = ROOT_LINK;
        end else begin
          moved[q] = i;
          moved[i] = q;
        end
        expect_beat(write_links(moved, w), 1'b0);
        expect_beat(same, 1'b1);
      end else if (p != i + 1) begin
        // both occupied, not mates: join the partners, root passes along
        moved[i]   = VACANT;
        moved[i+1] = VACANT;
        if (p == ROOT_LINK) begin
          if (q >= 0) moved[q] = ROOT_LINK;
        end else if (q == ROOT_LINK) begin
          if (p >= 0) moved[p] = ROOT_LINK;
        end else begin
          moved[p] = q;
          moved[q] = p;
        end
        expect_beat(write_links(moved, w), 1'b1);
      end
      // a mated L R pair at i, i+1 gives nothing
    endfunction

    function void check_result(logic [31:0] pattern, logic last);
      tile_beat_t exp_beat;
      if (expected_beats.size() == 0) begin
        $error("unexpected out beat: pattern_out %h last %b", pattern, last);
        errors++;
        return;
      end
      exp_beat = expected_beats.pop_front();
      if (pattern !== exp_beat.pattern) begin
        $error("pattern_out mismatch: expected %h, actual %h", exp_beat.pattern, pattern);
        errors++;
      end
      if (last !== exp_beat.last) begin
        $error("last mismatch: expected %b, actual %b", exp_beat.last, last);
        errors++;
      end
    endfunction
  endclass

  // ---------------------------------------------------------------------------
  // Clock, reset, DUT
  // ---------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [31:0] in_pattern = '0;
  logic [3:0]  in_position = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_pattern_out;
  logic        out_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_word_width = '0;

  tile_scoreboard sb = new();

  int unsigned cycle_count = 0;
  int          burst_left = 0;   // beats left in the current sender burst
  int          in_range_count;   // beats of the phase that can give results

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  link_pattern_tile_step uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pattern     (in_pattern),
    .in_position    (in_position),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_pattern_out(out_pattern_out),
    .out_last       (out_last),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_word_width (cfg_word_width)
  );

  // Watchdog: any hang ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: stall pattern switches mode every so often.
  // Mode 0 never stalls, 1 stalls lightly, 2 heavily, 3 on a fixed duty cycle.
  // ---------------------------------------------------------------------------
  int unsigned stall_mode = 0;
  int unsigned stall_hold = 0;
  int unsigned stall_tick = 0;

  always @(negedge clk) begin
    if (stall_hold == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_hold <= $urandom_range(30, 200);
    end else begin
      stall_hold <= stall_hold - 1;
    end
    stall_tick <= stall_tick + 1;
    case (stall_mode)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 3) == 0);
      end
      2: begin
        out_stall <= ($urandom_range(0, 3) != 0);
      end
      default: begin
        out_stall <= (stall_tick % 5 < 3);
      end
    endcase
  end

  // Out beat monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_pattern_out, out_last);
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Drive one input beat, hold it until taken, then maybe open a gap.
  task automatic send_beat(logic [31:0] pattern, logic [3:0] pos);
    int gap;
    @(negedge clk);
    in_valid    <= 1'b1;
    in_pattern  <= pattern;
    in_position <= pos;
    do @(posedge clk); while (in_stall);
    sb.note_input(pattern, pos);
    if (int'(pos) + 1 < sb.span()) in_range_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        @(negedge clk);
        in_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      // long bursts give stretches with no sender idling
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  // Build a word from symbol letters, position 0 first; missing positions are N.
  function automatic logic [31:0] sym_word(string s);
    logic [31:0] word;
    word = '0;
    for (int k = 0; k < s.len() && k < lpts_pkg::PATTERN_SLOTS; k++) begin
      case (s[k])
        "R": word[2*k +: 2] = lpts_pkg::SYM_R;
        "L": word[2*k +: 2] = lpts_pkg::SYM_L;
        "3": word[2*k +: 2] = SYM_JUNK;
        default: word[2*k +: 2] = lpts_pkg::SYM_N;
      endcase
    end
    return word;
  endfunction

  // Well-formed word of width w with at most one defect and random content.
  function automatic logic [31:0] chain_word(int w);
    logic [31:0] word;
    logic [1:0]  sym;
    int depth, rem, pick;
    bit have_root;
    word = '0;
    depth = 0;
    have_root = 0;
    for (int k = 0; k < w; k++) begin
      rem  = w - k;
      pick = $urandom_range(0, 3);
      if (depth == rem) begin
        sym = lpts_pkg::SYM_R;
      end else if (pick == 0) begin
        sym = lpts_pkg::SYM_N;
      end else if (pick == 1) begin
        sym = (depth + 1 <= rem - 1) ? lpts_pkg::SYM_L : lpts_pkg::SYM_N;
      end else if (depth > 0) begin
        sym = lpts_pkg::SYM_R;
      end else if (!have_root) begin
        sym = lpts_pkg::SYM_R;
        have_root = 1;
      end else begin
        sym = (depth + 1 <= rem - 1) ? lpts_pkg::SYM_L : lpts_pkg::SYM_N;
      end
      if (sym == lpts_pkg::SYM_L) depth++;
      else if (sym == lpts_pkg::SYM_R && (depth > 0) && !(pick >= 2 && depth == 0)) depth--;
      word[2*k +: 2] = sym;
    end
    return word;
  endfunction

  // Random beats: mostly well-formed words, some with junk above the width or
  // an unused code, plus raw noise; positions mostly in range.
  task automatic random_beats(int count);
    logic [31:0] word, keep;
    logic [3:0]  pos;
    int w;
    in_range_count = 0;
    while (in_range_count < count) begin
      w = sb.span();
      if ($urandom_range(0, 6) == 0) begin
        word = $urandom();
      end else begin
        word = chain_word(w);
        keep = (w >= 16) ? 32'hFFFF_FFFF : ((32'd1 << (2 * w)) - 1);
        if ($urandom_range(0, 3) == 0) word = word | ($urandom() & ~keep);
        if ($urandom_range(0, 7) == 0) word[2 * $urandom_range(0, w - 1) +: 2] = SYM_JUNK;
      end
      if ($urandom_range(0, 7) == 0) pos = 4'($urandom_range(0, 15));
      else pos = 4'($urandom_range(0, w - 2));
      send_beat(word, pos);
    end
  endtask

  // Drop the sender, wait for all expected beats, then for any result-free
  // item still in flight.
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(logic [4:0] v);
    @(negedge clk);
    in_valid       <= 1'b0;
    cfg_valid      <= 1'b1;
    cfg_word_width <= v;
    do @(posedge clk); while (!cfg_ready);
    sb.set_width(v);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  logic [4:0] phase_width [PHASES] =
    '{5'd16, 5'd2, 5'd31, 5'd0, 5'd9, 5'd1, 5'd3, 5'd17, 5'd12, 5'd16};

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset width of 16.
    send_beat(sym_word(""), 4'd0);                  // both vacant
    send_beat(sym_word("R"), 4'd0);                 // root at i only
    send_beat(sym_word("NR"), 4'd0);                // root at i+1 only
    send_beat(sym_word("LNR"), 4'd0);               // mated L at i only
    send_beat(sym_word("LNR"), 4'd1);               // mated R at i+1 only
    send_beat(sym_word("LR"), 4'd0);                // mate pair, no beat
    send_beat(sym_word("RLR"), 4'd0);               // root at i, partner takes root
    send_beat(sym_word("LRLR"), 4'd1);              // join two partners
    send_beat(sym_word("LRR"), 4'd1);               // root at i+1
    send_beat(sym_word("RR"), 4'd0);                // second stray R reads as N
    send_beat(sym_word("L"), 4'd0);                 // unclosed L reads as N
    send_beat(sym_word("3R"), 4'd0);                // unused code
    send_beat(32'hFFFF_FFFF, 4'd7);                 // all unused codes
    send_beat(32'h5555_5555, 4'd0);                 // all R
    send_beat(32'hAAAA_AAAA, 4'd14);                // all L
    send_beat(sym_word("LR"), 4'd15);               // position out of range
    send_beat(sym_word("NNNNNNNNNNNNNNNR"), 4'd14); // top position, root
    send_beat(sym_word("NNNNNNNNNNNNNNLR"), 4'd14); // top mate pair
    send_beat(sym_word("LLRR"), 4'd0);
    send_beat(sym_word("LLRR"), 4'd1);
    send_beat(sym_word("RLLRLR"), 4'd3);
    send_beat(sym_word("LNNNNNNNNNNNNNNR"), 4'd0);
    send_beat(32'h0, 4'd14);

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph > 0) begin
        drain();
        write_width((ph == PHASES - 1) ? 5'($urandom_range(0, 31)) : phase_width[ph]);
      end
      random_beats(PHASE_ITEMS);
    end

    @(negedge clk);
    in_valid <= 1'b0;
    drain();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/lpts_pkg.sv
sv/lpts_cell.sv
sv/lpts_scan.sv
sv/link_pattern_tile_step.sv
bench/tb_link_pattern_tile_step.sv
